// File: src/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and round functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    localparam int unsigned DIGEST_WORDS = 5;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [5:0] LAST_FILL  = 6'd63;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_IDX   = 3'd4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        t_src       wr_src;
        logic       count_add;
        logic       load_len;
        logic       start_comp;
        logic       round_en;
        logic [1:0] phase;
        logic       add_h;
        logic       init;
        logic [2:0] out_idx;
        logic       out_last;
    } t_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [1:0] phase);
        case (phase)
            2'd0:    round_k = 32'h5A827999;
            2'd1:    round_k = 32'h6ED9EBA1;
            2'd2:    round_k = 32'h8F1BBCDC;
            default: round_k = 32'hCA62C1D6;
        endcase
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        case (phase)
            2'd0:    round_f = (b & c) | (~b & d);
            2'd2:    round_f = (b & c) | (b & d) | (c & d);
            default: round_f = b ^ c ^ d;
        endcase
    endfunction

endpackage

// File: src/sha1s_dp.sv
// ----------------------------------------------------------------------------
// sha1s_dp
// Datapath: block buffer / schedule window, round unit, chaining words and
// message bit count.
// ----------------------------------------------------------------------------
module sha1s_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sha1s_pkg::t_cmd i_cmd,
    input  logic [7:0]      i_data_byte,
    output logic [31:0]     o_digest_word
);

    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [sha1s_pkg::DIGEST_WORDS];
    logic [63:0] r_count;

    logic [7:0]  w_byte;
    logic [1:0]  w_lane;
    logic [31:0] w_sched;
    logic [31:0] w_temp;

    always_comb begin
        case (i_cmd.wr_src)
            sha1s_pkg::SRC_DATA: w_byte = i_data_byte;
            sha1s_pkg::SRC_PAD:  w_byte = sha1s_pkg::PAD_BYTE;
            default:             w_byte = 8'h00;
        endcase
    end

    assign w_lane  = 2'd3 - i_cmd.wr_addr[1:0];
    assign w_sched = sha1s_pkg::rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign w_temp  = sha1s_pkg::rotl(r_a, 5) + sha1s_pkg::round_f(i_cmd.phase, r_b, r_c, r_d)
                   + r_e + sha1s_pkg::round_k(i_cmd.phase) + r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            for (int k = 0; k < 16; k++) begin
                if (4'(k) == i_cmd.wr_addr[5:2]) begin
                    r_w[k][{w_lane, 3'b000} +: 8] <= w_byte;
                end
            end
        end
        if (i_cmd.load_len) begin
            r_w[14] <= r_count[63:32];
            r_w[15] <= r_count[31:0];
        end
        if (i_cmd.round_en) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[15] <= w_sched;
        end
        if (i_cmd.start_comp) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= w_temp;
            r_b <= r_a;
            r_c <= sha1s_pkg::rotl(r_b, 30);
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= sha1s_pkg::IV;
            r_count <= 64'd0;
        end else if (i_cmd.init) begin
            r_h     <= sha1s_pkg::IV;
            r_count <= 64'd0;
        end else begin
            if (i_cmd.count_add) begin
                r_count <= r_count + 64'd8;
            end
            if (i_cmd.add_h) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    always_comb begin
        case (i_cmd.out_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            default: o_digest_word = r_h[4];
        endcase
    end

endmodule

// File: src/sha1s_ctrl.sv
// ----------------------------------------------------------------------------
// sha1s_ctrl
// Controller: byte fill, padding sequence, round count and digest output.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_operation,
    input  logic            i_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output sha1s_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_FIN
    } t_ret;

    t_state     r_state, n_state;
    t_ret       r_ret, n_ret;
    logic [5:0] r_fill, n_fill;
    logic [6:0] r_cnt, n_cnt;
    logic [2:0] r_idx, n_idx;
    logic       r_wrap, n_wrap;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_wrap  = r_wrap;

        o_cmd          = '0;
        o_cmd.wr_src   = sha1s_pkg::SRC_ZERO;
        o_cmd.wr_addr  = r_fill;
        o_cmd.out_idx  = r_idx;
        o_cmd.out_last = (r_idx == sha1s_pkg::LAST_IDX);
        if (r_cnt < 7'd20) begin
            o_cmd.phase = 2'd0;
        end else if (r_cnt < 7'd40) begin
            o_cmd.phase = 2'd1;
        end else if (r_cnt < 7'd60) begin
            o_cmd.phase = 2'd2;
        end else begin
            o_cmd.phase = 2'd3;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.wr_en = 1'b1;
                    n_fill      = r_fill + 6'd1;
                    if (i_operation == sha1s_pkg::OP_ABSORB) begin
                        o_cmd.wr_src    = sha1s_pkg::SRC_DATA;
                        o_cmd.count_add = 1'b1;
                        if (r_fill == sha1s_pkg::LAST_FILL) begin
                            o_cmd.start_comp = 1'b1;
                            n_ret   = RET_IDLE;
                            n_cnt   = 7'd0;
                            n_state = S_ROUND;
                        end
                    end else begin
                        o_cmd.wr_src = sha1s_pkg::SRC_PAD;
                        n_wrap  = (r_fill >= sha1s_pkg::LEN_OFFSET);
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_wrap && r_fill == 6'd0) begin
                    // length does not fit: flush this block first
                    o_cmd.start_comp = 1'b1;
                    n_wrap  = 1'b0;
                    n_ret   = RET_PAD;
                    n_cnt   = 7'd0;
                    n_state = S_ROUND;
                end else if (!r_wrap && r_fill == sha1s_pkg::LEN_OFFSET) begin
                    o_cmd.load_len   = 1'b1;
                    o_cmd.start_comp = 1'b1;
                    n_fill  = 6'd0;
                    n_ret   = RET_FIN;
                    n_cnt   = 7'd0;
                    n_state = S_ROUND;
                end else begin
                    o_cmd.wr_en = 1'b1;
                    n_fill      = r_fill + 6'd1;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_cnt == sha1s_pkg::LAST_ROUND) begin
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.add_h = 1'b1;
                case (r_ret)
                    RET_IDLE: n_state = S_IDLE;
                    RET_PAD:  n_state = S_PAD;
                    default: begin
                        n_idx   = 3'd0;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (r_idx == sha1s_pkg::LAST_IDX) begin
                        o_cmd.init = 1'b1;
                        n_fill     = 6'd0;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_IDLE;
            r_fill  <= 6'd0;
            r_cnt   <= 7'd0;
            r_idx   <= 3'd0;
            r_wrap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_wrap  <= n_wrap;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx <= sha1s_pkg::LAST_IDX))
        else $error("digest word index out of range");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_cnt <= sha1s_pkg::LAST_ROUND))
        else $error("round count out of range");

    a_fill_after_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add_h |-> (r_fill == 6'd0))
        else $error("block buffer not empty after compression");

    a_last_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_ready && o_cmd.out_last) |=> (o_in_ready && r_fill == 6'd0))
        else $error("not ready for new message after digest");

    a_no_wrap_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_wrap)
        else $error("padding wrap flag left set");

endmodule

// File: src/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 over a byte stream; emits the 160-bit digest as five 32-bit words.
// ----------------------------------------------------------------------------
// One item is in work at a time. An absorb item writes its byte into the block
// buffer; the one that fills a 64-byte block also starts a compression: 80
// rounds on the single round unit, then a fold into the chaining words. A
// finish item writes the 0x80 marker and zero padding one byte per cycle,
// runs one or two compressions (a start step, 80 rounds and the fold), and
// then presents five digest words, one per output handshake. After the fifth
// word the hasher is back in idle with the chaining words and bit count reset,
// ready for the next message.
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha1s_pkg::t_cmd w_cmd;

    sha1s_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_ready     (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    sha1s_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .o_digest_word (o_digest_word)
    );

    assign o_word_index = w_cmd.out_idx;
    assign o_last_word  = w_cmd.out_last;

endmodule
